@@ rtl/kcl_pkg.sv @@
// Shared constants for the keypad code lock: field widths, register
// indexes and register reset values. No dependencies.
`default_nettype none

package kcl_pkg;

   localparam int CODE_LENGTH_DEFAULT = 12;

   localparam int KEY_W     = 4;
   localparam int LEVELS_W  = 16;
   localparam int COUNT_W   = 8;
   localparam int CODE_W    = 48;
   localparam int CSR_IDX_W = 2;

   // Packed widths of the stream words, rounded up to whole bytes.
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_KEYS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAR_KEY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BACK_KEY  = 2'd2;

   localparam logic [CODE_W-1:0] CODE_KEYS_RESET = 48'd266439157291545;
   localparam logic [KEY_W-1:0]  CLEAR_KEY_RESET = 4'd12;
   localparam logic [KEY_W-1:0]  BACK_KEY_RESET  = 4'd13;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

endpackage : kcl_pkg

`default_nettype wire

@@ rtl/keypad_code_lock.sv @@
// Keypad code lock, top level: scan register, press detection, lock state
// update and result register. Depends on kcl_pkg.
//
// One word on req_ is one full scan of a 4x4 keypad (active-low levels).
// The block takes one scan per clock while the result side is not stalled, and
// returns exactly one result word per scan: the scan is registered in the input
// register, then press detection, priority encoding and the lock state update
// run combinationally into the result register. The lock state loop closes
// on the way into the result register, so scans may follow each other in every
// cycle while rsp_tready is high. A result waiting on rsp_ stops the next scan
// from entering the input register once that register is full. Configuration
// writes on csr_ are always accepted and should only be issued while no scan is in flight.
`default_nettype none

module keypad_code_lock #(
   parameter int CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // req_tdata: [15:0] key_levels
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [kcl_pkg::REQ_DATA_W-1:0]  req_tdata,
   // rsp_tdata: [0] key_taken, [4:1] key_index, [8:5] lock_state,
   // [9] unlocked, [17:10] fault_count, [23:18] zero
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [kcl_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [kcl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [kcl_pkg::CODE_W-1:0]      csr_data
);
   import kcl_pkg::*;

   // Step codes: 0..CODE_LENGTH-1 matched keys, then unlocked, then fault.
   localparam int STEP_W = $clog2(CODE_LENGTH + 2);
   localparam logic [STEP_W-1:0] UNLOCK_CODE = STEP_W'(CODE_LENGTH);
   localparam logic [STEP_W-1:0] FAULT_CODE  = STEP_W'(CODE_LENGTH + 1);
   localparam int CODE_EXT_W = 64;

   // Configuration registers.
   logic [CODE_W-1:0] code_keys_ff;
   logic [KEY_W-1:0]  clear_key_ff;
   logic [KEY_W-1:0]  back_key_ff;

   // Input register.
   logic                s1_valid_ff;
   logic [LEVELS_W-1:0] s1_levels_ff;

   // Lock state.
   logic               any_was_pressed_ff, any_was_pressed_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [COUNT_W-1:0] wrong_ff, wrong_in;
   logic [STEP_W-1:0]  return_ff, return_in;

   // Result register.
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  out_free;
   logic                  advance;
   logic [LEVELS_W-1:0]   pressed;
   logic                  any_now;
   logic                  taken;
   logic [KEY_W-1:0]      key;
   logic [KEY_W-1:0]      expected;
   logic [CODE_EXT_W-1:0] code_ext;
   logic [KEY_W-1:0]      step_nib;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_keys_ff <= CODE_KEYS_RESET;
         clear_key_ff <= CLEAR_KEY_RESET;
         back_key_ff  <= BACK_KEY_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CODE_KEYS: code_keys_ff <= csr_data;
            CSR_CLEAR_KEY: clear_key_ff <= csr_data[KEY_W-1:0];
            CSR_BACK_KEY:  back_key_ff  <= csr_data[KEY_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_levels_ff <= req_tdata[LEVELS_W-1:0];
      end
   end

   // Lowest pressed key wins.
   always_comb begin
      pressed = ~s1_levels_ff;
      any_now = |pressed;
      key     = '0;
      for (int i = LEVELS_W - 1; i >= 0; i--) begin
         if (pressed[i]) begin
            key = KEY_W'(i);
         end
      end
   end

   assign taken = any_now && !any_was_pressed_ff;

   // Steps beyond the twelve nibbles of the code register expect key zero.
   assign code_ext = {{(CODE_EXT_W - CODE_W){1'b0}}, code_keys_ff};
   assign step_nib = KEY_W'(step_ff);
   assign expected = code_ext[{step_nib, 2'b00} +: KEY_W];

   always_comb begin
      any_was_pressed_in = any_now;
      step_in            = step_ff;
      wrong_in           = wrong_ff;
      return_in          = return_ff;
      if (taken) begin
         if (step_ff == FAULT_CODE) begin
            if (key == clear_key_ff) begin
               step_in  = '0;
               wrong_in = '0;
            end else if (key == back_key_ff) begin
               if (wrong_ff <= COUNT_W'(1)) begin
                  wrong_in = '0;
                  step_in  = return_ff;
               end else begin
                  wrong_in = wrong_ff - COUNT_W'(1);
               end
            end else if (wrong_ff != COUNT_MAX) begin
               wrong_in = wrong_ff + COUNT_W'(1);
            end
         end else if (step_ff == UNLOCK_CODE) begin
            if (key == clear_key_ff) begin
               step_in = '0;
            end
         end else if (key == expected) begin
            step_in = step_ff + STEP_W'(1);
         end else if (key == clear_key_ff) begin
            step_in = '0;
         end else if (key == back_key_ff && step_ff != '0) begin
            step_in = step_ff - STEP_W'(1);
         end else begin
            return_in = step_ff;
            step_in   = FAULT_CODE;
            if (wrong_ff != COUNT_MAX) begin
               wrong_in = wrong_ff + COUNT_W'(1);
            end
         end
      end
   end

   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in[0]     = taken;
      rsp_data_in[4:1]   = key;
      rsp_data_in[8:5]   = KEY_W'(step_in);
      rsp_data_in[9]     = (step_in == UNLOCK_CODE);
      rsp_data_in[17:10] = wrong_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         any_was_pressed_ff <= 1'b0;
         step_ff            <= '0;
         wrong_ff           <= '0;
         return_ff          <= '0;
      end else if (advance) begin
         any_was_pressed_ff <= any_was_pressed_in;
         step_ff            <= step_in;
         wrong_ff           <= wrong_in;
         return_ff          <= return_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef NO_ASSERTIONS
   // A waiting result always reflects the current lock state.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[17:10] == wrong_ff &&
                        rsp_data_ff[9] == (step_ff == UNLOCK_CODE)))
      else $error("result word disagrees with lock state");

   // Outstanding wrong keys exist only in the fault state.
   assert property (@(posedge clock) disable iff (reset)
      (wrong_ff != '0) |-> (step_ff == FAULT_CODE))
      else $error("wrong-key count outside fault state");

   assert property (@(posedge clock) disable iff (reset)
      step_ff <= FAULT_CODE)
      else $error("step code out of range");

   // A taken key implies a key is now held.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[0]) |-> any_was_pressed_ff)
      else $error("key taken without a held key");
`endif

endmodule : keypad_code_lock

`default_nettype wire

@@ test/keypad_code_lock_checker.sv @@
// Scoreboard for the keypad code lock: watches the scan, result and register
// channels, predicts every result word and compares it field by field.
// Depends on kcl_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps

module keypad_code_lock_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic [kcl_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [kcl_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  wire logic                            csr_valid,
   input  wire logic                            csr_ready,
   input  wire logic [kcl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [kcl_pkg::CODE_W-1:0]      csr_data,
   output int                                   mismatches,
   output int                                   results_due
);
   import kcl_pkg::*;

   localparam logic [KEY_W-1:0] STEP_UNLOCKED = KEY_W'(CODE_LENGTH_DEFAULT);
   localparam logic [KEY_W-1:0] STEP_FAULT    = KEY_W'(CODE_LENGTH_DEFAULT + 1);

   // Same bit order as rsp_tdata[17:0], key_taken in bit 0.
   typedef struct packed {
      logic [COUNT_W-1:0] fault_count;
      logic               unlocked;
      logic [KEY_W-1:0]   lock_state;
      logic [KEY_W-1:0]   key_index;
      logic               key_taken;
   } lock_result_type;

   logic [CODE_W-1:0]  code_cfg;
   logic [KEY_W-1:0]   clear_cfg;
   logic [KEY_W-1:0]   back_cfg;
   logic               was_down;
   logic [KEY_W-1:0]   step;
   logic [COUNT_W-1:0] wrong_cnt;
   logic [KEY_W-1:0]   resume_step;

   lock_result_type lock_results_due[$];
   lock_result_type want;
   lock_result_type got;
   int              errors;

   initial begin
      mismatches  = 0;
      results_due = 0;
      errors      = 0;
   end

   function automatic lock_result_type predict_lock_result(
      input logic [LEVELS_W-1:0] levels);
      lock_result_type     r;
      logic [LEVELS_W-1:0] down;
      logic [KEY_W-1:0]    key;
      down = ~levels;
      key  = '0;
      for (int i = LEVELS_W - 1; i >= 0; i--) begin
         if (down[i]) key = KEY_W'(i);
      end
      r.key_taken = (|down) && !was_down;
      if (r.key_taken) begin
         if (step == STEP_FAULT) begin
            if (key == clear_cfg) begin
               step      = '0;
               wrong_cnt = '0;
            end else if (key == back_cfg) begin
               if (wrong_cnt != 0) wrong_cnt = wrong_cnt - 1'b1;
               if (wrong_cnt == 0) step = resume_step;
            end else if (wrong_cnt != COUNT_MAX) begin
               wrong_cnt = wrong_cnt + 1'b1;
            end
         end else if (step == STEP_UNLOCKED) begin
            if (key == clear_cfg) step = '0;
         end else if (key == code_cfg[4*step +: KEY_W]) begin
            step = step + 1'b1;
         end else if (key == clear_cfg) begin
            step = '0;
         end else if (key == back_cfg && step != 0) begin
            step = step - 1'b1;
         end else begin
            // A wrong key remembers where entry stood so backing out can resume.
            resume_step = step;
            step        = STEP_FAULT;
            if (wrong_cnt != COUNT_MAX) wrong_cnt = wrong_cnt + 1'b1;
         end
      end
      was_down      = |down;
      r.key_index   = key;
      r.lock_state  = step;
      r.unlocked    = (step == STEP_UNLOCKED);
      r.fault_count = wrong_cnt;
      return r;
   endfunction

   task automatic check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                  $time, name, expected, actual);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         code_cfg    = CODE_KEYS_RESET;
         clear_cfg   = CLEAR_KEY_RESET;
         back_cfg    = BACK_KEY_RESET;
         was_down    = 1'b0;
         step        = '0;
         wrong_cnt   = '0;
         resume_step = '0;
         lock_results_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(lock_result_type)-1:0];
            if (lock_results_due.size() == 0) begin
               $display("%0t ns: result word with none expected, expected nothing, actual %h",
                        $time, rsp_tdata);
               errors++;
            end else begin
               want = lock_results_due.pop_front();
               check_field("key_taken", want.key_taken, got.key_taken);
               check_field("key_index", want.key_index, got.key_index);
               check_field("lock_state", want.lock_state, got.lock_state);
               check_field("unlocked", want.unlocked, got.unlocked);
               check_field("fault_count", want.fault_count, got.fault_count);
               check_field("padding", 0, rsp_tdata[RSP_DATA_W-1:$bits(lock_result_type)]);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CODE_KEYS: code_cfg  = csr_data;
               CSR_CLEAR_KEY: clear_cfg = csr_data[KEY_W-1:0];
               CSR_BACK_KEY:  back_cfg  = csr_data[KEY_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            lock_results_due.push_back(predict_lock_result(req_tdata));
      end
      mismatches  <= errors;
      results_due <= lock_results_due.size();
   end

endmodule

@@ test/keypad_code_lock_tb.sv @@
// Top of the keypad code lock testbench: clock, reset, scan and register
// stimulus, result back-pressure and the verdict. Depends on kcl_pkg, the
// keypad_code_lock block and keypad_code_lock_checker.
`timescale 1ns / 1ps

module keypad_code_lock_tb;
   import kcl_pkg::*;

   localparam int CODE_LENGTH = CODE_LENGTH_DEFAULT;
   localparam int SCAN_TARGET = 1070;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CODE_W-1:0]      csr_data;
   int                     mismatches;
   int                     results_due;

   // Local copy of the registers, used to build meaningful key sequences.
   logic [CODE_W-1:0] code_cfg;
   logic [KEY_W-1:0]  clear_cfg;
   logic [KEY_W-1:0]  back_cfg;
   bit                idle_on;
   bit                flood_done;
   int                scans_sent;
   int                stall_left;

   keypad_code_lock i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   keypad_code_lock_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .results_due (results_due)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Result side: random stall bursts while idling is enabled.
   initial begin
      rsp_tready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(1, 18) - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

   task automatic drive_scan(input logic [LEVELS_W-1:0] levels);
      int gap;
      gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= levels;
      do @(posedge clock); while (!req_tready);
      scans_sent++;
   endtask

   // Press one key as the lowest one down, sometimes follow with a random scan, usually release.
   task automatic tap(input logic [KEY_W-1:0] key);
      logic [LEVELS_W-1:0] lv;
      lv = LEVELS_W'($urandom) | ((16'd1 << key) - 16'd1);
      lv[key] = 1'b0;
      drive_scan(lv);
      if ($urandom_range(0, 5) == 0) drive_scan(LEVELS_W'($urandom));
      if ($urandom_range(0, 15) != 0) drive_scan(16'hFFFF);
   endtask

   function automatic logic [KEY_W-1:0] pick_wrong_key(input logic [KEY_W-1:0] avoid);
      logic [KEY_W-1:0] k;
      do k = KEY_W'($urandom); while (k == avoid || k == clear_cfg || k == back_cfg);
      return k;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CODE_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stop sending and wait until every result word has come back.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic set_lock(input logic [CODE_W-1:0] code, input logic [KEY_W-1:0] clr,
                           input logic [KEY_W-1:0] bk);
      settle();
      write_reg(CSR_CODE_KEYS, code);
      write_reg(CSR_CLEAR_KEY, CODE_W'(clr));
      write_reg(CSR_BACK_KEY, CODE_W'(bk));
      code_cfg  = code;
      clear_cfg = clr;
      back_cfg  = bk;
   endtask

   task automatic run_sequence();
      int kind;
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
         // Mostly correct code entry with occasional slips along the way.
         for (int s = 0; s < CODE_LENGTH; s++) begin
            case ($urandom_range(0, 24))
               0: tap(pick_wrong_key(code_cfg[4*s +: KEY_W]));
               1: tap(back_cfg);
               2: tap(clear_cfg);
               default: ;
            endcase
            tap(code_cfg[4*s +: KEY_W]);
         end
         repeat ($urandom_range(0, 3)) tap(KEY_W'($urandom));
         if ($urandom_range(0, 3) != 0) tap(clear_cfg);
      end else if (kind <= 6) begin
         tap(KEY_W'($urandom));
         repeat ($urandom_range(0, 4)) tap(KEY_W'($urandom));
         repeat ($urandom_range(0, 6)) tap(back_cfg);
      end else if (kind == 7) begin
         repeat ($urandom_range(1, 8))
            drive_scan(($urandom_range(0, 3) == 0) ? 16'hFFFF : LEVELS_W'($urandom));
      end else if (kind == 8) begin
         tap(clear_cfg);
      end else begin
         drive_scan(16'h0000);
         repeat ($urandom_range(0, 3)) drive_scan(LEVELS_W'($urandom) & 16'h7FFF);
         drive_scan(16'hFFFF);
      end
   endtask

   initial begin
      logic [CODE_W-1:0] code;
      logic [KEY_W-1:0]  clr;
      logic [KEY_W-1:0]  bk;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      idle_on    = 1'b0;
      flood_done = 1'b0;
      scans_sent = 0;
      code_cfg   = CODE_KEYS_RESET;
      clear_cfg  = CLEAR_KEY_RESET;
      back_cfg   = BACK_KEY_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part under the reset register values.
      drive_scan(16'hFFFF);
      drive_scan(16'h0000);
      drive_scan(16'h0000);
      drive_scan(16'hFFFF);
      drive_scan(16'h7FFF);
      drive_scan(16'hFFFF);
      drive_scan(~(16'd1 << clear_cfg));
      drive_scan(16'hFFFF);
      drive_scan(~(16'd1 << back_cfg));
      drive_scan(16'hFFFF);
      drive_scan(~(16'd1 << pick_wrong_key(back_cfg)));
      drive_scan(16'hFFFF);
      drive_scan(~(16'd1 << back_cfg));
      drive_scan(16'hFFFF);
      drive_scan(~(16'd1 << back_cfg));
      drive_scan(16'hFFFF);
      drive_scan(~(16'd1 << code_cfg[3:0]));
      drive_scan(16'hFFFF);
      drive_scan(~(16'd1 << back_cfg));
      drive_scan(16'hFFFF);
      drive_scan(~(16'd1 << code_cfg[3:0]));
      drive_scan(16'hFFFF);
      drive_scan(~(16'd1 << pick_wrong_key(code_cfg[7:4])));
      drive_scan(16'hFFFF);
      drive_scan(~(16'd1 << clear_cfg));
      drive_scan(16'hFFFF);

      settle();
      write_reg(CSR_UNUSED, CODE_W'({$urandom, $urandom}));

      while (scans_sent < SCAN_TARGET) begin
         code = CODE_W'({$urandom, $urandom});
         clr  = KEY_W'($urandom);
         bk   = KEY_W'($urandom);
         case ($urandom_range(0, 7))
            0: set_lock(CODE_KEYS_RESET, CLEAR_KEY_RESET, BACK_KEY_RESET);
            2: set_lock('0, 4'd0, 4'd15);
            3: set_lock('1, 4'd15, 4'd0);
            4: set_lock(code, clr, clr);
            5: begin
               // Code keys that coincide with the clear and back keys.
               code[3:0] = clr;
               code[11:8] = bk;
               set_lock(code, clr, bk);
            end
            default: set_lock(code, clr, bk);
         endcase
         idle_on = (scans_sent < SCAN_TARGET - 150) && ($urandom_range(0, 3) != 0);
         if (!flood_done && scans_sent > 400) begin
            // Drive the wrong-key count into saturation, step it back with the back key, then clear it.
            set_lock(CODE_KEYS_RESET, CLEAR_KEY_RESET, BACK_KEY_RESET);
            tap(clear_cfg);
            tap(back_cfg);
            repeat (262) begin
               drive_scan(~(16'd1 << pick_wrong_key(back_cfg)));
               drive_scan(16'hFFFF);
            end
            repeat (3) tap(back_cfg);
            tap(clear_cfg);
            flood_done = 1'b1;
         end
         repeat ($urandom_range(4, 12)) run_sequence();
      end

      idle_on = 1'b0;
      settle();
      repeat (10) @(negedge clock);
      if (mismatches == 0 && results_due == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ keypad_code_lock.f @@
rtl/kcl_pkg.sv
rtl/keypad_code_lock.sv
test/keypad_code_lock_checker.sv
test/keypad_code_lock_tb.sv
